// ----- sv/nlsc_pkg.sv -----
// nlsc_pkg: formats, constants and result packing for the natural log block
// no dependencies; used by natural_log_series_or_cfrac
package nlsc_pkg;

    localparam int MAX_TERMS       = 255;
    localparam int INPUT_FRAC_BITS = 16;

    localparam logic [31:0] ONE_IN   = 32'(64'd1 << INPUT_FRAC_BITS);
    localparam logic [63:0] QUOT_CAP = (64'd1 << 62) - 64'd1;
    localparam logic [31:0] NEG_MAX  = 32'h8000_0000;
    localparam logic [31:0] POS_MAX  = 32'h7FFF_FFFF;

    localparam logic [6:0] DIV_BITS_SHORT = 7'd32;
    localparam logic [6:0] DIV_BITS_FRAC  = 7'd62;

    // Q.32 magnitude plus sign to saturated Q8.24 two's complement
    function automatic logic [31:0] to_q824(input logic [63:0] mag32, input logic neg);
        logic [55:0] m;
        logic [31:0] res;
        m = mag32[63:8];
        if (neg)
        begin
            if (m >= 56'h8000_0000)
                res = NEG_MAX;
            else
                res = 32'(~m[31:0] + 32'd1);
        end
        else
        begin
            if (m > 56'h7FFF_FFFF)
                res = POS_MAX;
            else
                res = m[31:0];
        end
        return res;
    endfunction

endpackage

// ----- sv/natural_log_series_or_cfrac.sv -----
// natural_log_series_or_cfrac: ln(x) by Taylor series or continued fraction
// sequencer around one shared 32x32 multiplier and one radix-2 divider
// depends on nlsc_pkg
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_ready, mode, x_value,        | in
//          | term_count                               |
//  output  | out_valid, out_ready, log_value, status   | out
//
// one item at a time; in_ready is high only while the sequencer is idle
// taylor: a 32-step division plus one multiply per term
// cfrac: two multiplies and a 62-step division per level
// x of zero or one goes from idle straight to the output state; the divider's one bit a cycle sets the rate
// reset clears the sequencer state and the divider count only; a stalled result holds until its transfer
module natural_log_series_or_cfrac (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [31:0] x_value,
    input  logic [7:0]  term_count,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] log_value,
    output logic        status
);
    import nlsc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_T_RDIV, S_T_DIV, S_T_MUL, S_C_QDIV, S_C_Q2,
        S_C_KK, S_C_NUM, S_C_DIV, S_C_FIN, S_C_FDIV, S_OUT
    } state_t;

    state_t      state_reg, state_next;
    logic        neg_reg, neg_next;
    logic [7:0]  n_reg, n_next;
    logic [7:0]  idx_reg, idx_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] p_reg, p_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] cf_reg, cf_next;
    logic [31:0] ma_reg, ma_next;
    logic [31:0] mb_reg, mb_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dl_reg, dl_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dvs_reg, dvs_next;
    logic [6:0]  dcnt_reg, dcnt_next;
    logic [31:0] log_value_reg, log_value_next;
    logic        status_reg, status_next;

    logic [63:0] prod;
    logic [64:0] trial;
    logic [64:0] trial_sub;
    logic [7:0]  n_clamp;
    logic [31:0] diff;
    logic [7:0]  k_dec;
    logic [63:0] sum_add;
    logic [47:0] num;
    logic        num_cap;
    logic [63:0] fin_a;
    logic        fin_cap;
    logic [63:0] quot_sel;
    logic [63:0] cf_upd;

    // shared multiplier, operands registered at issue
    assign prod = 64'(ma_reg) * 64'(mb_reg);

    // one restoring step of the shared divider
    assign trial     = {rem_reg, dl_reg[63]};
    assign trial_sub = trial - {1'b0, dvs_reg};

    assign n_clamp = (term_count == 8'd0) ? 8'd1
                   : ((16'(term_count) > 16'(MAX_TERMS)) ? 8'(MAX_TERMS) : term_count);
    assign diff    = (x_value < ONE_IN) ? (ONE_IN - x_value) : (x_value - ONE_IN);
    assign k_dec   = idx_reg - 8'd1;
    assign sum_add = sum_reg + quo_reg;
    assign num     = prod[47:0];
    assign num_cap = {46'd0, num} >= {cf_reg, 30'd0};
    assign fin_a   = {31'd0, r_reg, 1'b0};
    assign fin_cap = {30'd0, fin_a} >= {cf_reg, 30'd0};

    // fraction level update: cf = (2k-1) - quot, kept positive
    assign quot_sel = (state_reg == S_C_NUM) ? QUOT_CAP : quo_reg;
    always_comb
    begin
        logic [63:0] base;
        logic [63:0] t;
        base = ({55'd0, idx_reg, 1'b0} - 64'd1) << 32;
        t    = base - quot_sel;
        if ($signed(t) <= 64'sd0)
            cf_upd = 64'd1;
        else
            cf_upd = t;
    end

    // sequencer and divider
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        r_next         = r_reg;
        p_next         = p_reg;
        sum_next       = sum_reg;
        cf_next        = cf_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        dvs_next       = dvs_reg;
        log_value_next = log_value_reg;
        status_next    = status_reg;
        rem_next       = rem_reg;
        dl_next        = dl_reg;
        quo_next       = quo_reg;
        dcnt_next      = dcnt_reg;

        if (dcnt_reg != 7'd0)
        begin
            dl_next   = {dl_reg[62:0], 1'b0};
            dcnt_next = dcnt_reg - 7'd1;
            if (!trial_sub[64])
            begin
                rem_next = trial_sub[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next   = n_clamp;
                    neg_next = x_value < ONE_IN;
                    sum_next = 64'd0;
                    quo_next = 64'd0;
                    if (x_value == 32'd0)
                    begin
                        log_value_next = NEG_MAX;
                        status_next    = 1'b1;
                        state_next     = S_OUT;
                    end
                    else if (x_value == ONE_IN)
                    begin
                        log_value_next = 32'd0;
                        status_next    = 1'b0;
                        state_next     = S_OUT;
                    end
                    else if (!mode)
                    begin
                        status_next = 1'b0;
                        if (x_value < ONE_IN)
                        begin
                            r_next    = diff << (32 - INPUT_FRAC_BITS);
                            p_next    = diff << (32 - INPUT_FRAC_BITS);
                            idx_next  = 8'd1;
                            rem_next  = 64'd0;
                            dl_next   = {diff << (32 - INPUT_FRAC_BITS), 32'd0};
                            dvs_next  = 64'd1;
                            dcnt_next = DIV_BITS_SHORT;
                            state_next = S_T_DIV;
                        end
                        else
                        begin
                            rem_next  = {32'd0, diff};
                            dl_next   = 64'd0;
                            dvs_next  = {32'd0, x_value};
                            dcnt_next = DIV_BITS_SHORT;
                            state_next = S_T_RDIV;
                        end
                    end
                    else
                    begin
                        status_next = 1'b0;
                        rem_next    = {32'd0, diff};
                        dl_next     = 64'd0;
                        dvs_next    = {32'd0, x_value} + {32'd0, ONE_IN};
                        dcnt_next   = DIV_BITS_SHORT;
                        state_next  = S_C_QDIV;
                    end
                end
            end
            S_T_RDIV:
            begin
                if (dcnt_reg == 7'd0)
                begin
                    r_next    = quo_reg[31:0];
                    p_next    = quo_reg[31:0];
                    idx_next  = 8'd1;
                    rem_next  = 64'd0;
                    dl_next   = {quo_reg[31:0], 32'd0};
                    quo_next  = 64'd0;
                    dvs_next  = 64'd1;
                    dcnt_next = DIV_BITS_SHORT;
                    state_next = S_T_DIV;
                end
            end
            S_T_DIV:
            begin
                if (dcnt_reg == 7'd0)
                begin
                    sum_next = sum_add;
                    if (idx_reg == n_reg)
                    begin
                        log_value_next = to_q824(sum_add, neg_reg);
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        ma_next    = p_reg;
                        mb_next    = r_reg;
                        state_next = S_T_MUL;
                    end
                end
            end
            S_T_MUL:
            begin
                p_next    = prod[63:32];
                idx_next  = idx_reg + 8'd1;
                rem_next  = 64'd0;
                dl_next   = {prod[63:32], 32'd0};
                quo_next  = 64'd0;
                dvs_next  = {56'd0, idx_reg + 8'd1};
                dcnt_next = DIV_BITS_SHORT;
                state_next = S_T_DIV;
            end
            S_C_QDIV:
            begin
                if (dcnt_reg == 7'd0)
                begin
                    r_next     = quo_reg[31:0];
                    ma_next    = quo_reg[31:0];
                    mb_next    = quo_reg[31:0];
                    state_next = S_C_Q2;
                end
            end
            S_C_Q2:
            begin
                p_next   = prod[63:32];
                cf_next  = ({55'd0, n_reg, 1'b0} - 64'd1) << 32;
                idx_next = n_reg - 8'd1;
                ma_next  = {24'd0, n_reg - 8'd1};
                mb_next  = {24'd0, n_reg - 8'd1};
                if (n_reg == 8'd1)
                    state_next = S_C_FIN;
                else
                    state_next = S_C_KK;
            end
            S_C_KK:
            begin
                ma_next    = p_reg;
                mb_next    = prod[31:0];
                state_next = S_C_NUM;
            end
            S_C_NUM:
            begin
                if (num_cap)
                begin
                    cf_next  = cf_upd;
                    idx_next = k_dec;
                    ma_next  = {24'd0, k_dec};
                    mb_next  = {24'd0, k_dec};
                    state_next = (k_dec == 8'd0) ? S_C_FIN : S_C_KK;
                end
                else
                begin
                    rem_next  = {46'd0, num[47:30]};
                    dl_next   = {num[29:0], 34'd0};
                    quo_next  = 64'd0;
                    dvs_next  = cf_reg;
                    dcnt_next = DIV_BITS_FRAC;
                    state_next = S_C_DIV;
                end
            end
            S_C_DIV:
            begin
                if (dcnt_reg == 7'd0)
                begin
                    cf_next  = cf_upd;
                    idx_next = k_dec;
                    ma_next  = {24'd0, k_dec};
                    mb_next  = {24'd0, k_dec};
                    state_next = (k_dec == 8'd0) ? S_C_FIN : S_C_KK;
                end
            end
            S_C_FIN:
            begin
                if (fin_cap)
                begin
                    log_value_next = to_q824(QUOT_CAP, neg_reg);
                    state_next     = S_OUT;
                end
                else
                begin
                    rem_next  = {30'd0, fin_a[63:30]};
                    dl_next   = {fin_a[29:0], 34'd0};
                    quo_next  = 64'd0;
                    dvs_next  = cf_reg;
                    dcnt_next = DIV_BITS_FRAC;
                    state_next = S_C_FDIV;
                end
            end
            S_C_FDIV:
            begin
                if (dcnt_reg == 7'd0)
                begin
                    log_value_next = to_q824(quo_reg, neg_reg);
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, datapath and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dcnt_reg  <= 7'd0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg       <= neg_next;
        n_reg         <= n_next;
        idx_reg       <= idx_next;
        r_reg         <= r_next;
        p_reg         <= p_next;
        sum_reg       <= sum_next;
        cf_reg        <= cf_next;
        ma_reg        <= ma_next;
        mb_reg        <= mb_next;
        rem_reg       <= rem_next;
        dl_reg        <= dl_next;
        quo_reg       <= quo_next;
        dvs_reg       <= dvs_next;
        log_value_reg <= log_value_next;
        status_reg    <= status_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign log_value = log_value_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    // divider never runs while idle or presenting a result
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_OUT) |-> dcnt_reg == 7'd0)
        else $error("divider busy outside computation");

    // minus-infinity status carries the most negative value
    a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> log_value == NEG_MAX)
        else $error("status set with wrong value");

    // an input transfer leads straight out of idle
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("still idle after input transfer");
`endif

endmodule
